// File: rtl/bswc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bswc_pkg
// Shared widths and defaults for the bubble sort core.
// ----------------------------------------------------------------------------
package bswc_pkg;

    localparam int DATA_W        = 32;  // element width
    localparam int CNT_W         = 11;  // compare / exchange count width
    localparam int USER_W        = 24;  // m_tuser width, padded to bytes
    localparam int DEF_MAX_ITEMS = 64;  // default store depth

endpackage

`default_nettype wire

// File: rtl/bubble_sort_with_counts_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bubble_sort_with_counts_core
// Collects a set of signed values, bubble sorts it in place and streams it out.
// ----------------------------------------------------------------------------
// Elements arrive one per cycle on the slave stream while the core is
// loading (s_tready is low while it sorts or emits); the transaction with
// tlast set closes the set and starts an ascending bubble sort on the
// MAX_ITEMS-deep element memory (one read and one write port, registered
// read). Elements past capacity are dropped and flagged. Each pass carries
// the running maximum in a register and writes back one entry per cycle.
// Each result is then read from memory and loaded into the output register
// before the next read starts, and a read waits until the output register is
// free. The next set may load while the last result is still waiting on
// the master side. Every result carries the set's compare and exchange
// counts and the overflow flag. No clearing pass is needed after reset.
module bubble_sort_with_counts_core
    import bswc_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [DATA_W-1:0] s_tdata,   // [31:0] value
    input  wire logic              s_tlast,   // last_item
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,   // [31:0] sorted_value
    output logic                   m_tlast,   // is_last
    output logic [USER_W-1:0]      m_tuser    // [10:0] compare_count,
                                              // [21:11] exchange_count,
                                              // [22] overflowed, [23] zero
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    typedef enum logic [6:0] {
        ST_LOAD    = 7'b0000001,
        ST_PRIME   = 7'b0000010,
        ST_FIRST   = 7'b0000100,
        ST_CMP     = 7'b0001000,
        ST_PEND    = 7'b0010000,
        ST_EMIT_RD = 7'b0100000,
        ST_EMIT_LD = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]   cmp_reg, cmp_next;
    logic [CNT_W-1:0]   exch_reg, exch_next;
    logic               drop_reg, drop_next;
    logic [AW-1:0]      limit_reg, limit_next;
    logic [AW-1:0]      pair_reg, pair_next;
    logic [AW-1:0]      emit_reg, emit_next;
    logic [DATA_W-1:0]  carry_reg, carry_next;

    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic               out_last_reg, out_last_next;
    logic [USER_W-1:0]  out_user_reg, out_user_next;

    // element memory
    logic [DATA_W-1:0]  mem [MAX_ITEMS];
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [DATA_W-1:0]  mem_wdata, mem_rdata;

    logic               s_accept;
    logic [CW-1:0]      cnt_inc;
    logic               emit_last;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_rdata <= mem[mem_raddr];
        end
    end

    assign s_tready  = (state_reg == ST_LOAD);
    assign s_accept  = s_tvalid && s_tready;
    assign cnt_inc   = (cnt_reg < CW'(MAX_ITEMS)) ? cnt_reg + CW'(1) : cnt_reg;
    assign emit_last = (CW'(emit_reg) + CW'(1)) == cnt_reg;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmp_next       = cmp_reg;
        exch_next      = exch_reg;
        drop_next      = drop_reg;
        limit_next     = limit_reg;
        pair_next      = pair_reg;
        emit_next      = emit_reg;
        carry_next     = carry_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        out_valid_next = out_valid_reg && !m_tready;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    if (cnt_reg < CW'(MAX_ITEMS)) begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_reg[AW-1:0];
                        mem_wdata = s_tdata;
                    end else begin
                        drop_next = 1'b1;
                    end
                    cnt_next = cnt_inc;
                    if (s_tlast) begin
                        cmp_next  = '0;
                        exch_next = '0;
                        emit_next = '0;
                        if (cnt_inc < CW'(2)) begin
                            state_next = ST_EMIT_RD;
                        end else begin
                            limit_next = AW'(cnt_inc - CW'(1));
                            state_next = ST_PRIME;
                        end
                    end
                end
            end
            ST_PRIME: begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                pair_next  = '0;
                state_next = ST_FIRST;
            end
            ST_FIRST: begin
                carry_next = mem_rdata;
                mem_re     = 1'b1;
                mem_raddr  = AW'(1);
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // carry holds the largest element seen so far in this pass
                cmp_next  = cmp_reg + CNT_W'(1);
                mem_we    = 1'b1;
                mem_waddr = pair_reg;
                if ($signed(carry_reg) > $signed(mem_rdata)) begin
                    exch_next = exch_reg + CNT_W'(1);
                    mem_wdata = mem_rdata;
                end else begin
                    mem_wdata  = carry_reg;
                    carry_next = mem_rdata;
                end
                if ((pair_reg + AW'(1)) < limit_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = pair_reg + AW'(2);
                    pair_next = pair_reg + AW'(1);
                end else begin
                    state_next = ST_PEND;
                end
            end
            ST_PEND: begin
                mem_we     = 1'b1;
                mem_waddr  = limit_reg;
                mem_wdata  = carry_reg;
                limit_next = limit_reg - AW'(1);
                state_next = (limit_reg == AW'(1)) ? ST_EMIT_RD : ST_PRIME;
            end
            ST_EMIT_RD: begin
                // read only when the output register is free next cycle
                if (!out_valid_reg || m_tready) begin
                    mem_re     = 1'b1;
                    mem_raddr  = emit_reg;
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                out_valid_next = 1'b1;
                out_data_next  = mem_rdata;
                out_last_next  = emit_last;
                out_user_next  = {1'b0, drop_reg, exch_reg, cmp_reg};
                if (emit_last) begin
                    cnt_next   = '0;
                    cmp_next   = '0;
                    exch_next  = '0;
                    drop_next  = 1'b0;
                    state_next = ST_LOAD;
                end else begin
                    emit_next  = emit_reg + AW'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            cmp_reg       <= '0;
            exch_reg      <= '0;
            drop_reg      <= 1'b0;
            limit_reg     <= '0;
            pair_reg      <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_reg       <= cmp_next;
            exch_reg      <= exch_next;
            drop_reg      <= drop_next;
            limit_reg     <= limit_next;
            pair_reg      <= pair_next;
            emit_reg      <= emit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        carry_reg    <= carry_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

`ifndef SYNTH
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(MAX_ITEMS))
        else $error("element count beyond capacity");

    a_exch_le_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        exch_reg <= cmp_reg)
        else $error("more exchanges than compares");

    a_pair_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CMP) |-> (pair_reg < limit_reg))
        else $error("pair index past pass limit");

    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_LD) |-> !out_valid_reg)
        else $error("output register overwritten while holding a result");

    a_pass_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PEND) |=> (limit_reg == $past(limit_reg) - AW'(1)))
        else $error("pass limit did not shrink");
`endif

endmodule

`default_nettype wire
